// File: src/checksum_packet_deframer_unit_assert.svh
// ----------------------------------------------------------------------------
// Checksum packet deframer assertion macros
// Concurrent assertion wrappers used by the deframer top level.
// ----------------------------------------------------------------------------
`ifndef CHECKSUM_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define CHECKSUM_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// Check a property while reset is released.
`define CPD_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/cpd_pkg.sv
// ----------------------------------------------------------------------------
// Checksum packet deframer package
// Shared widths, result kind codes and the result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] START_DELIM_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_DELIM_RST   = 8'h55;

    localparam logic [CFG_IDX_W-1:0] CFG_START_DELIM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_DELIM   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
    } result_t;

endpackage

`default_nettype wire

// File: src/cpd_in_stage.sv
// ----------------------------------------------------------------------------
// Checksum packet deframer input stage
// Registers one received byte and holds it until the core advances.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_in_stage
    import cpd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,
    input  wire logic              advance,
    output logic                   byte_valid,
    output logic [BYTE_W-1:0]      byte_data
);

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    assign s_tready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// File: src/cpd_core.sv
// ----------------------------------------------------------------------------
// Checksum packet deframer core
// Frame state machine, delimiter registers and inverted modulo-256 checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_core
    import cpd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_wr_data,
    input  wire logic                 advance,
    input  wire logic [BYTE_W-1:0]    byte_data,
    output result_t                   result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK,
        PH_END
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] seen_reg, seen_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              match_reg, match_next;
    logic [BYTE_W-1:0] start_delim_reg;
    logic [BYTE_W-1:0] end_delim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delim_reg <= START_DELIM_RST;
            end_delim_reg   <= END_DELIM_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_DELIM: start_delim_reg <= cfg_wr_data;
                CFG_END_DELIM:   end_delim_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        sum_next    = sum_reg;
        match_next  = match_reg;
        result      = '0;
        if (byte_data == start_delim_reg) begin
            if (phase_reg != PH_IDLE) begin
                result.valid = 1'b1;
                result.kind  = KIND_ABORT;
                result.data  = length_reg;
            end
            phase_next  = PH_LENGTH;
            length_next = '0;
            seen_next   = '0;
            sum_next    = '0;
            match_next  = 1'b0;
        end else begin
            unique case (phase_reg)
                PH_LENGTH: begin
                    length_next = byte_data;
                    seen_next   = '0;
                    sum_next    = '0;
                    phase_next  = (byte_data == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    sum_next     = sum_reg + byte_data;
                    seen_next    = seen_reg + 1'b1;
                    result.valid = 1'b1;
                    result.kind  = KIND_PAYLOAD;
                    result.data  = byte_data;
                    if (seen_next == length_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    match_next = (byte_data == ~sum_reg);
                    phase_next = PH_END;
                end
                PH_END: begin
                    result.valid = 1'b1;
                    result.kind  = (match_reg && byte_data == end_delim_reg) ?
                                   KIND_GOOD : KIND_ERROR;
                    result.data  = length_reg;
                    phase_next   = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        if (!advance) begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            length_reg <= '0;
            seen_reg   <= '0;
            sum_reg    <= '0;
            match_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
            sum_reg    <= sum_next;
            match_reg  <= match_next;
        end
    end

endmodule

`default_nettype wire

// File: src/cpd_out_stage.sv
// ----------------------------------------------------------------------------
// Checksum packet deframer output stage
// Result register feeding the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_out_stage
    import cpd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire result_t           result,
    output logic                   out_free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,
    output logic [KIND_W-1:0]      m_tuser
);

    logic              valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] data_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= result.valid;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            kind_reg <= result.kind;
            data_reg <= result.data;
        end
    end

endmodule

`default_nettype wire

// File: src/checksum_packet_deframer_unit.sv
// An input transfer is registered in the input stage; its result is then registered in the output stage for m_tvalid.
// Throughput: one byte per cycle while the output is not stalled; the frame state
// updates once per byte in the core between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers, returns the frame
// state to idle and restores start 0xAA / end 0x55 delimiters.
// ----------------------------------------------------------------------------
// Checksum packet deframer top level
// Length-prefixed frame deframer with inverted modulo-256 payload checksum.
// ----------------------------------------------------------------------------
`default_nettype none
`include "checksum_packet_deframer_unit_assert.svh"

module checksum_packet_deframer_unit
    import cpd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [BYTE_W-1:0]         m_tdata,   // [7:0] data
    output logic [KIND_W-1:0]         m_tuser    // [1:0] kind
);

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              out_free;
    logic              advance;
    result_t           result;

    assign advance = byte_valid && out_free;

    cpd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    cpd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .byte_data   (byte_data),
        .result      (result)
    );

    cpd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `CPD_ASSERT_RST(a_result_lands, aclk, aresetn, (advance && result.valid) |=> m_tvalid, "result dropped before output register")
    `CPD_ASSERT_RST(a_byte_held, aclk, aresetn, (byte_valid && !advance) |=> (byte_valid && $stable(byte_data)), "pending byte lost while stalled")
    `CPD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!m_tvalid && !byte_valid), "pipeline not empty after reset")

endmodule

`default_nettype wire
